/* design/ppse_pkg.sv */
`timescale 1ns / 1ps
package ppse_pkg;

  localparam int T_BITS      = 32;  // timestamp width
  localparam int DT_BITS     = 33;  // signed time difference
  localparam int SPEED_BITS  = 31;  // signed Q speed result
  localparam int OUT_W       = 64;  // result tdata, byte padded
  localparam int QUEUE_DEPTH = 2;   // jobs between front and back

  // queue status seen by both ends
  typedef struct packed {
    logic full;
    logic valid;
  } q_status_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SQUARE,
    B_ROOT,
    B_DIVIDE,
    B_DONE
  } back_state_t;

endpackage

/* design/ppse_front.sv */
`timescale 1ns / 1ps
module ppse_front #(
  parameter int POS_BITS = 20,
  parameter int JOB_W    = 3 * (POS_BITS + 1) + ppse_pkg::DT_BITS + ppse_pkg::T_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [POS_BITS-1:0]        pos_x,
  input  logic [POS_BITS-1:0]        pos_y,
  input  logic [POS_BITS-1:0]        pos_z,
  input  logic [ppse_pkg::T_BITS-1:0] sample_time,
  input  logic                       alive,
  input  logic                       preset,
  input  logic                       range_end,
  input  ppse_pkg::q_status_t        q_st,
  output logic                       push,
  output logic [JOB_W-1:0]           push_data
);

  localparam int DW = POS_BITS + 1;

  logic                        have_start_r, have_start_nxt;
  logic [POS_BITS-1:0]         start_x_r, start_y_r, start_z_r;
  logic [ppse_pkg::T_BITS-1:0] start_stamp_r;
  logic                        load_start;
  logic                        acc;
  logic [DW-1:0]               dx, dy, dz;
  logic [ppse_pkg::DT_BITS-1:0] dt;

  assign in_ready = !q_st.full;
  assign acc      = in_valid && in_ready;

  // sign-extended differences against the held start point
  assign dx = {pos_x[POS_BITS-1], pos_x} - {start_x_r[POS_BITS-1], start_x_r};
  assign dy = {pos_y[POS_BITS-1], pos_y} - {start_y_r[POS_BITS-1], start_y_r};
  assign dz = {pos_z[POS_BITS-1], pos_z} - {start_z_r[POS_BITS-1], start_z_r};
  assign dt = {1'b0, sample_time} - {1'b0, start_stamp_r};

  assign push      = acc && alive && have_start_r;
  assign push_data = {start_stamp_r, dt, dz, dy, dx};

  always_comb begin
    have_start_nxt = have_start_r;
    load_start     = 1'b0;
    if (acc) begin
      if (!alive) begin
        if (range_end) begin
          have_start_nxt = 1'b0;
        end
      end else if (range_end || preset) begin
        have_start_nxt = 1'b0;
      end else begin
        have_start_nxt = 1'b1;
        load_start     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_start_r <= 1'b0;
    end else begin
      have_start_r <= have_start_nxt;
    end
  end

  // start point is only read while have_start_r is set
  always_ff @(posedge clk) begin
    if (load_start) begin
      start_x_r     <= pos_x;
      start_y_r     <= pos_y;
      start_z_r     <= pos_z;
      start_stamp_r <= sample_time;
    end
  end

endmodule

/* design/ppse_queue.sv */
`timescale 1ns / 1ps
module ppse_queue #(
  parameter int WIDTH = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic [WIDTH-1:0]    push_data,
  input  logic                pop,
  output logic [WIDTH-1:0]    pop_data,
  output ppse_pkg::q_status_t st
);

  localparam int DEPTH = ppse_pkg::QUEUE_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign st.full   = (count_r == CW'(DEPTH));
  assign st.valid  = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    st.full && !pop |-> !push)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> st.valid)
    else $error("queue read while empty");

endmodule

/* design/ppse_back.sv */
`timescale 1ns / 1ps
module ppse_back #(
  parameter int POS_BITS  = 20,
  parameter int FRAC_BITS = 8,
  parameter int JOB_W     = 3 * (POS_BITS + 1) + ppse_pkg::DT_BITS + ppse_pkg::T_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ppse_pkg::q_status_t              q_st,
  input  logic [JOB_W-1:0]                 q_data,
  output logic                             q_pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [ppse_pkg::SPEED_BITS-1:0]  out_speed,
  output logic [ppse_pkg::T_BITS-1:0]      out_time,
  output logic                             out_zero
);

  localparam int DW   = POS_BITS + 1;             // coordinate difference
  localparam int SQW  = 2 * POS_BITS;             // one squared term
  localparam int SW   = 2 * POS_BITS + 2;         // sum of three squares
  localparam int RW   = POS_BITS + 1 + FRAC_BITS; // root bits
  localparam int RWE  = RW + (RW % 2);            // rounded up to whole pairs
  localparam int RADW = 2 * RWE;                  // radicand bits
  localparam int RMW  = RWE + 3;                  // root remainder
  localparam int NSQ  = RWE / 2;                  // root steps, two bits each
  localparam int NDV  = RWE / 2;                  // divide steps, two bits each
  localparam int SQ_TERMS = 3;
  localparam int NMAX = (NSQ > SQ_TERMS + 1) ? NSQ : SQ_TERMS + 1;
  localparam int CW   = $clog2(NMAX + 1);
  localparam int QXW  = (RWE > ppse_pkg::SPEED_BITS) ? RWE : ppse_pkg::SPEED_BITS;
  localparam int DTB  = ppse_pkg::DT_BITS;
  localparam int TB   = ppse_pkg::T_BITS;
  localparam logic [ppse_pkg::SPEED_BITS-1:0] HALF_Q =
    ppse_pkg::SPEED_BITS'((64'd1 << FRAC_BITS) >> 1);

  ppse_pkg::back_state_t state_r, state_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  load_out;

  logic signed [DW-1:0]  dx_r, dx_nxt, dy_r, dy_nxt, dz_r, dz_nxt;
  logic [TB-1:0]         time_r, time_nxt;
  logic [TB-1:0]         dmag_r, dmag_nxt;
  logic                  neg_r, neg_nxt, zero_r, zero_nxt;
  logic [SQW-1:0]        sq_r, sq_nxt;
  logic [SW-1:0]         sum_r, sum_nxt;
  logic [RADW-1:0]       rad_r, rad_nxt;
  logic [RWE-1:0]        root_r, root_nxt;
  logic [RMW-1:0]        srem_r, srem_nxt;
  logic [RWE-1:0]        dvd_r, dvd_nxt;
  logic [TB-1:0]         drem_r, drem_nxt;
  logic [ppse_pkg::SPEED_BITS-1:0] out_speed_r, out_speed_nxt;
  logic [TB-1:0]         out_time_r, out_time_nxt;
  logic                  out_zero_r, out_zero_nxt;

  logic [DTB-1:0]        job_dt;

  assign job_dt    = q_data[3*DW +: DTB];
  assign out_valid = out_valid_r;
  assign out_speed = out_speed_r;
  assign out_time  = out_time_r;
  assign out_zero  = out_zero_r;

  always_comb begin
    logic signed [DW-1:0]    op_v;
    logic signed [2*DW-1:0]  prod_v;
    logic [RADW-1:0]         rad_v;
    logic [RWE-1:0]          root_v;
    logic [RMW-1:0]          rem_v;
    logic [RMW-1:0]          trial_v;
    logic [RWE-1:0]          dvd_v;
    logic [TB:0]             dr_v;
    logic [TB-1:0]           drem_v;
    logic [DTB-1:0]          dtabs_v;
    logic [QXW-1:0]          qx_v;

    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    q_pop         = 1'b0;
    load_out      = 1'b0;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    dz_nxt        = dz_r;
    time_nxt      = time_r;
    dmag_nxt      = dmag_r;
    neg_nxt       = neg_r;
    zero_nxt      = zero_r;
    sq_nxt        = sq_r;
    sum_nxt       = sum_r;
    rad_nxt       = rad_r;
    root_nxt      = root_r;
    srem_nxt      = srem_r;
    dvd_nxt       = dvd_r;
    drem_nxt      = drem_r;
    out_speed_nxt = out_speed_r;
    out_time_nxt  = out_time_r;
    out_zero_nxt  = out_zero_r;

    op_v    = dx_r;
    prod_v  = '0;
    rad_v   = rad_r;
    root_v  = root_r;
    rem_v   = srem_r;
    trial_v = '0;
    dvd_v   = dvd_r;
    dr_v    = '0;
    drem_v  = drem_r;
    dtabs_v = job_dt[DTB-1] ? -job_dt : job_dt;
    qx_v    = QXW'(dvd_r);

    case (state_r)
      ppse_pkg::B_IDLE: begin
        if (q_st.valid) begin
          q_pop     = 1'b1;
          dx_nxt    = q_data[0 +: DW];
          dy_nxt    = q_data[DW +: DW];
          dz_nxt    = q_data[2*DW +: DW];
          time_nxt  = q_data[3*DW + DTB +: TB];
          dmag_nxt  = dtabs_v[TB-1:0];
          neg_nxt   = job_dt[DTB-1];
          zero_nxt  = (job_dt == '0);
          sum_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ppse_pkg::B_SQUARE;
        end
      end
      ppse_pkg::B_SQUARE: begin
        // one shared multiplier; the sum adds the registered product in the next cycle
        case (cnt_r)
          CW'(0):  op_v = dx_r;
          CW'(1):  op_v = dy_r;
          default: op_v = dz_r;
        endcase
        prod_v = op_v * op_v;
        sq_nxt = prod_v[SQW-1:0];
        if (cnt_r != '0) begin
          sum_nxt = sum_r + SW'(sq_r);
        end
        if (cnt_r == CW'(SQ_TERMS)) begin
          rad_nxt   = RADW'(sum_r + SW'(sq_r)) << (2 * FRAC_BITS);
          root_nxt  = '0;
          srem_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = ppse_pkg::B_ROOT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ppse_pkg::B_ROOT: begin
        // digit-by-digit root, two result bits per cycle
        for (int i = 0; i < 2; i++) begin
          rem_v   = {rem_v[RMW-3:0], rad_v[RADW-1 -: 2]};
          rad_v   = rad_v << 2;
          trial_v = {1'b0, root_v, 2'b01};
          if (rem_v >= trial_v) begin
            rem_v  = rem_v - trial_v;
            root_v = {root_v[RWE-2:0], 1'b1};
          end else begin
            root_v = {root_v[RWE-2:0], 1'b0};
          end
        end
        rad_nxt  = rad_v;
        root_nxt = root_v;
        srem_nxt = rem_v;
        if (cnt_r == CW'(NSQ - 1)) begin
          dvd_nxt   = root_v;
          drem_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = ppse_pkg::B_DIVIDE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ppse_pkg::B_DIVIDE: begin
        // restoring divide, quotient shifts into the dividend register
        for (int i = 0; i < 2; i++) begin
          dr_v  = {drem_v, dvd_v[RWE-1]};
          dvd_v = dvd_v << 1;
          if (dr_v >= {1'b0, dmag_r}) begin
            dr_v     = dr_v - {1'b0, dmag_r};
            dvd_v[0] = 1'b1;
          end
          drem_v = dr_v[TB-1:0];
        end
        dvd_nxt  = dvd_v;
        drem_nxt = drem_v;
        if (cnt_r == CW'(NDV - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ppse_pkg::B_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ppse_pkg::B_DONE: begin
        if (neg_r) begin
          qx_v = -qx_v;
        end
        if (!out_valid_r || out_ready) begin
          load_out      = 1'b1;
          out_speed_nxt = zero_r ? HALF_Q : qx_v[ppse_pkg::SPEED_BITS-1:0];
          out_time_nxt  = time_r;
          out_zero_nxt  = zero_r;
          state_nxt     = ppse_pkg::B_IDLE;
        end
      end
      default: begin
        state_nxt = ppse_pkg::B_IDLE;
      end
    endcase

    out_valid_nxt = (out_valid_r && !out_ready) || load_out;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ppse_pkg::B_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dx_r        <= dx_nxt;
    dy_r        <= dy_nxt;
    dz_r        <= dz_nxt;
    time_r      <= time_nxt;
    dmag_r      <= dmag_nxt;
    neg_r       <= neg_nxt;
    zero_r      <= zero_nxt;
    sq_r        <= sq_nxt;
    sum_r       <= sum_nxt;
    rad_r       <= rad_nxt;
    root_r      <= root_nxt;
    srem_r      <= srem_nxt;
    dvd_r       <= dvd_nxt;
    drem_r      <= drem_nxt;
    out_speed_r <= out_speed_nxt;
    out_time_r  <= out_time_nxt;
    out_zero_r  <= out_zero_nxt;
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == ppse_pkg::B_IDLE) && q_st.valid)
    else $error("job taken while back end busy");

  a_root_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ppse_pkg::B_ROOT |-> srem_r <= RMW'({root_r, 1'b0}))
    else $error("root remainder out of range");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ppse_pkg::B_DIVIDE) && (dmag_r != '0) |-> drem_r < dmag_r)
    else $error("divide remainder out of range");

  a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ppse_pkg::B_DONE) && !zero_r |-> dvd_r <= root_r)
    else $error("quotient exceeds distance");

endmodule

/* design/point_pair_speed_estimator.sv */
`timescale 1ns / 1ps
// Path: an alive sample that pairs with a held start becomes a job in the queue; the back
//   end squares, roots and divides it and registers the result word for out_tvalid.
// Sharing: paired samples are worked one job at a time by the shared square,
//   root (two bits a cycle) and divide (two bits a cycle) unit; other samples wait only for queue room.
// Reset: rst_n synchronous, active low; drops the held start point, clears job queue and output valid.
module point_pair_speed_estimator #(
  parameter int POS_BITS  = 20,  // position width, 8 to 24
  parameter int FRAC_BITS = 8    // speed fraction bits, 0 to 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input words
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // pos_x, pos_y, pos_z (POS_BITS each), sample_time (32), zero pad
  input  logic [((3*POS_BITS+ppse_pkg::T_BITS+7)/8)*8-1:0] in_tdata,
  // alive, preset
  input  logic [1:0]                            in_tuser,
  // range_end
  input  logic                                  in_tlast,
  // result words
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // speed_q8 (31), start_time (32), zero pad
  output logic [ppse_pkg::OUT_W-1:0]            out_tdata,
  // zero_interval
  output logic                                  out_tuser
);

  localparam int DW    = POS_BITS + 1;
  localparam int JOB_W = 3 * DW + ppse_pkg::DT_BITS + ppse_pkg::T_BITS;
  localparam int TB    = ppse_pkg::T_BITS;
  localparam int SB    = ppse_pkg::SPEED_BITS;

  ppse_pkg::q_status_t     q_st;
  logic                    push, pop;
  logic [JOB_W-1:0]        push_data, pop_data;
  logic [SB-1:0]           speed;
  logic [TB-1:0]           stime;

  // Front: holds the start point, turns each pairing into a job of
  // differences (dx, dy, dz, dt) plus the start timestamp.
  ppse_front #(
    .POS_BITS (POS_BITS),
    .JOB_W    (JOB_W)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .pos_x       (in_tdata[POS_BITS-1:0]),
    .pos_y       (in_tdata[2*POS_BITS-1:POS_BITS]),
    .pos_z       (in_tdata[3*POS_BITS-1:2*POS_BITS]),
    .sample_time (in_tdata[3*POS_BITS+TB-1:3*POS_BITS]),
    .alive       (in_tuser[0]),
    .preset      (in_tuser[1]),
    .range_end   (in_tlast),
    .q_st        (q_st),
    .push        (push),
    .push_data   (push_data)
  );

  // Short job queue: the front keeps taking words while the back works, until the queue is full.
  ppse_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .st        (q_st)
  );

  // Back: sum of squares, fixed-point root, signed divide, output register.
  ppse_back #(
    .POS_BITS  (POS_BITS),
    .FRAC_BITS (FRAC_BITS),
    .JOB_W     (JOB_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_st      (q_st),
    .q_data    (pop_data),
    .q_pop     (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_speed (speed),
    .out_time  (stime),
    .out_zero  (out_tuser)
  );

  assign out_tdata = {{(ppse_pkg::OUT_W - SB - TB){1'b0}}, stime, speed};

endmodule

/* tb/sv/tb_point_pair_speed_estimator.sv */
`timescale 1ns / 1ps
module tb_point_pair_speed_estimator;

  localparam int POS_BITS      = 20;
  localparam int FRAC_BITS     = 8;
  localparam int IN_W          = ((3*POS_BITS + ppse_pkg::T_BITS + 7)/8)*8;
  // drain time after the last owed word, with margin
  localparam int SETTLE_CYCLES = 60;
  localparam int CYCLE_LIMIT   = 1000000;
  // four idling phases share the random budget (~1950 words with the directed set)
  localparam int RAND_PER_PHASE = 483;

  // one position sample as the sender sees it
  typedef struct {
    logic signed [POS_BITS-1:0] x;
    logic signed [POS_BITS-1:0] y;
    logic signed [POS_BITS-1:0] z;
    logic [31:0]                stamp;
    bit                         alive;
    bit                         preset;
    bit                         range_end;
  } sample_t;

  // expected result word
  typedef struct {
    logic [30:0] speed;
    logic [31:0] stamp;
    logic        zero;
  } speed_rec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                      in_tvalid = 1'b0;
  logic                      in_tready;
  logic [IN_W-1:0]           in_tdata = '0;   // pos_x, pos_y, pos_z, sample_time, zero pad
  logic [1:0]                in_tuser = '0;   // alive, preset
  logic                      in_tlast = 1'b0; // range_end
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [ppse_pkg::OUT_W-1:0] out_tdata;      // speed_q8, start_time, zero pad
  logic                      out_tuser;       // zero_interval

  point_pair_speed_estimator #(
    .POS_BITS (POS_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #4 clk = ~clk;

  // samples waiting for the driver, and the speeds still owed by the block
  sample_t    sample_q[$];
  speed_rec_t speed_due_q[$];

  int words_queued = 0;
  int words_taken  = 0;
  int mismatches   = 0;
  int cycle_count  = 0;

  // idle / stall odds in percent, set per phase
  int send_idle_pct  = 0;
  int take_stall_pct = 0;

  // predictor copy of the held start point
  bit      held_valid = 1'b0;
  sample_t held;

  // sample currently on the input bus
  sample_t cur_word;

  // random trace: last sample generated, so deltas stay realistic
  logic signed [POS_BITS-1:0] trace_x = '0;
  logic signed [POS_BITS-1:0] trace_y = '0;
  logic signed [POS_BITS-1:0] trace_z = '0;
  logic [31:0]                trace_t = '0;

  task automatic flag_mismatch(input string what, input longint unsigned want,
                               input longint unsigned got);
    $display("mismatch %s: expected 0x%0h, got 0x%0h at %0t", what, want, got, $realtime);
    mismatches++;
  endtask

  // floor(sqrt(v)), bit by bit
  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Advance the start-point tracker by one accepted word and queue the speed it owes.
  task automatic track_sample(input sample_t w);
    longint          dx, dy, dz, dt, mag;
    longint unsigned sumsq, span_q;
    speed_rec_t      rec;
    if (!w.alive) begin
      // dead sample: only a range boundary matters
      if (w.range_end) held_valid = 1'b0;
      return;
    end
    if (held_valid) begin
      dx = longint'(w.x) - longint'(held.x);
      dy = longint'(w.y) - longint'(held.y);
      dz = longint'(w.z) - longint'(held.z);
      sumsq = dx*dx + dy*dy + dz*dz;
      // distance in Q(FRAC_BITS): scale by 2^(2F) before the root
      span_q = floor_root(sumsq << (2*FRAC_BITS));
      dt = longint'(w.stamp) - longint'(held.stamp);
      rec.zero = (dt == 0);
      if (dt == 0) begin
        mag = (longint'(1) << FRAC_BITS) >> 1;  // half a unit per tick
      end else if (dt > 0) begin
        mag = longint'(span_q) / dt;
      end else begin
        mag = -(longint'(span_q) / (-dt));
      end
      rec.speed = mag[30:0];
      rec.stamp = held.stamp;
      speed_due_q.push_back(rec);
    end
    if (w.range_end || w.preset) begin
      held_valid = 1'b0;
    end else begin
      held_valid = 1'b1;
      held = w;
    end
  endtask

  task automatic queue_sample(input int x, input int y, input int z, input logic [31:0] t,
                              input bit a, input bit p, input bit e);
    sample_t s;
    s.x = x[POS_BITS-1:0];
    s.y = y[POS_BITS-1:0];
    s.z = z[POS_BITS-1:0];
    s.stamp = t;
    s.alive = a;
    s.preset = p;
    s.range_end = e;
    sample_q.push_back(s);
    words_queued++;
    trace_x = s.x;
    trace_y = s.y;
    trace_z = s.z;
    trace_t = t;
  endtask

  // Random words: mostly a smooth track (small steps, rising time), plus zero and
  // backward intervals, full-range noise, preset / range-end marks and dead samples.
  task automatic gen_burst(input int count);
    int          made, pick, step;
    int          x, y, z;
    logic [31:0] t;
    bit          a, p, e;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(99);
      step = ($urandom_range(3) == 0) ? 200000 : 2000;
      x = trace_x + int'($urandom_range(2*step)) - step;
      y = trace_y + int'($urandom_range(2*step)) - step;
      z = trace_z + int'($urandom_range(2*step)) - step;
      t = trace_t + (($urandom_range(4) == 0) ? $urandom_range(1, 15) : $urandom_range(1, 3000));
      a = 1'b1;
      p = 1'b0;
      e = 1'b0;
      if (pick < 60) begin
        // plain track step
      end else if (pick < 68) begin
        t = trace_t;
      end else if (pick < 74) begin
        t = trace_t - $urandom_range(1, 5000);
      end else if (pick < 80) begin
        x = int'($urandom);
        y = int'($urandom);
        z = int'($urandom);
        t = $urandom;
      end else if (pick < 85) begin
        p = 1'b1;
      end else if (pick < 90) begin
        e = 1'b1;
      end else if (pick < 95) begin
        a = 1'b0;
        p = ($urandom_range(1) != 0);
        e = ($urandom_range(1) != 0);
      end else begin
        t = $urandom;
        a = ($urandom_range(1) != 0);
        p = ($urandom_range(1) != 0);
        e = ($urandom_range(1) != 0);
      end
      queue_sample(x, y, z, t, a, p, e);
      made++;
    end
  endtask

  // Hold the sender until every queued word is taken and every speed has come out,
  // then let the pipeline run dry.
  task automatic settle();
    while (words_taken != words_queued) @(negedge clk);
    while (speed_due_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Driver: present the next sample when the slot is free, unless idling this cycle.
  always @(posedge clk) begin
    sample_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        track_sample(cur_word);
        words_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = sample_q.pop_front();
          cur_word  <= nxt;
          in_tvalid <= 1'b1;
          in_tdata  <= IN_W'({nxt.stamp, nxt.z, nxt.y, nxt.x});
          in_tuser  <= {nxt.preset, nxt.alive};
          in_tlast  <= nxt.range_end;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= take_stall_pct);
    end
  end

  // Monitor: every taken result word must match the oldest owed speed.
  always @(posedge clk) begin
    speed_rec_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (speed_due_q.size() == 0) begin
        flag_mismatch("unexpected result word", 0, out_tdata);
      end else begin
        want = speed_due_q.pop_front();
        if (out_tdata[30:0] !== want.speed)
          flag_mismatch("speed_q8", want.speed, out_tdata[30:0]);
        if (out_tdata[62:31] !== want.stamp)
          flag_mismatch("start_time", want.stamp, out_tdata[62:31]);
        if (out_tuser !== want.zero)
          flag_mismatch("zero_interval", want.zero, out_tuser);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int ph;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // --- directed words ---
    queue_sample(-524288, -524288, -524288, 32'd5, 0, 0, 0);   // dead, ignored
    queue_sample(-524288, -524288, -524288, 32'd0, 1, 0, 0);   // first start, no word
    queue_sample(524287, 524287, 524287, 32'd0, 1, 0, 0);      // zero interval -> half
    queue_sample(-524288, -524288, -524288, 32'd1, 1, 0, 0);   // widest span, dt = 1
    queue_sample(0, 0, 0, 32'd0, 1, 0, 0);                     // backward time
    queue_sample(524287, 0, -524288, 32'hFFFF_FFFF, 1, 0, 0);  // longest forward dt
    queue_sample(1, 2, 3, 32'd0, 1, 0, 0);                     // longest backward dt
    queue_sample(1, 2, -3, 32'd10, 1, 0, 0);                   // z-only move
    queue_sample(7, 7, 7, 32'd15, 0, 1, 0);                    // dead preset: start kept
    queue_sample(9, 9, 9, 32'd20, 1, 1, 0);                    // preset pairs, then drops
    queue_sample(100, 200, 300, 32'd30, 1, 0, 0);              // new start
    queue_sample(0, 0, 0, 32'd35, 0, 0, 1);                    // dead range end drops it
    queue_sample(-50, 60, -70, 32'd40, 1, 0, 0);               // no word, new start
    queue_sample(-40, 60, -70, 32'd50, 1, 0, 1);               // pairs, range end drops
    queue_sample(5, 5, 5, 32'd60, 1, 0, 1);                    // unpaired at range end
    queue_sample(5, 5, 5, 32'd70, 1, 0, 0);                    // start
    queue_sample(6, 5, 5, 32'd80, 1, 0, 1);                    // pairs, drops
    queue_sample(6, 5, 5, 32'd90, 1, 1, 0);                    // preset, no start: nothing
    queue_sample(10, 10, 10, 32'd100, 1, 0, 0);                // start
    queue_sample(10, 10, 10, 32'd100, 1, 0, 0);                // same point, dt = 0
    queue_sample(11, 10, 10, 32'd356, 1, 0, 0);                // exactly one unit
    queue_sample(11, 10, 10, 32'd357, 0, 1, 1);                // dead, all flags
    settle();

    // --- random phases: free flow, sender gaps, receiver stalls, both light ---
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        1: begin
          send_idle_pct  = 45;
          take_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          take_stall_pct = 45;
        end
        3: begin
          send_idle_pct  = 7;
          take_stall_pct = 7;
        end
        default: begin
          send_idle_pct  = 0;
          take_stall_pct = 0;
        end
      endcase
      gen_burst(RAND_PER_PHASE);
      settle();
    end

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* point_pair_speed_estimator.f */
design/ppse_pkg.sv
design/ppse_front.sv
design/ppse_queue.sv
design/ppse_back.sv
design/point_pair_speed_estimator.sv
tb/sv/tb_point_pair_speed_estimator.sv
